[rtl/drc_pkg.sv]
// Package: shared types and constants for the depth range colormap.
`timescale 1ns / 1ps

package drc_pkg;

  localparam int DEPTH_IN_W     = 16;  // width of the depth field on the port
  localparam int DEPTH_BITS_MAX = 32;  // widest supported range register
  localparam int CMD_W          = 2;
  localparam int CHAN_W         = 8;
  localparam int QUOT_BITS      = 8;   // quotient bits of the ramp divider
  localparam int QCNT_W         = $clog2(QUOT_BITS);

  localparam logic [CHAN_W-1:0] STOP_HI   = 8'd255;
  localparam logic [CHAN_W-1:0] STOP_LO   = 8'd15;
  localparam logic [CHAN_W-1:0] RAMP_GAIN = STOP_HI - STOP_LO;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_COLOR   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_DIV,
    ST_RESULT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN
  } div_state_t;

  typedef struct packed {
    logic                 done;
    logic                 rem_nz;
    logic [QUOT_BITS-1:0] quot;
  } div_stat_t;

endpackage

[rtl/drc_if.sv]
// Interfaces: depth request channel and color result channel.
`timescale 1ns / 1ps

interface drc_in_if;
  import drc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [DEPTH_IN_W-1:0] depth;

  modport source (output valid, output cmd, output depth, input ready);
  modport sink   (input valid, input cmd, input depth, output ready);
endinterface

interface drc_out_if;
  import drc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/drc_range.sv]
// Running minimum and maximum depth registers.
`timescale 1ns / 1ps

module drc_range #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd,
  input  logic                  clear,
  input  logic [DEPTH_BITS-1:0] depth,
  output logic [DEPTH_BITS-1:0] low,
  output logic [DEPTH_BITS-1:0] high
);
  import drc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '1;
      high <= '0;
    end else if (upd) begin
      if (clear) begin
        low  <= depth;
        high <= depth;
      end else begin
        if (depth < low) begin
          low <= depth;
        end
        if (depth > high) begin
          high <= depth;
        end
      end
    end
  end

endmodule

[rtl/drc_sdiv.sv]
// Bit-serial ramp divider: floor(RAMP_GAIN * t / span), one quotient bit a cycle.
`timescale 1ns / 1ps

module drc_sdiv #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DEPTH_BITS-1:0] t,
  input  logic [DEPTH_BITS-1:0] span,
  output drc_pkg::div_stat_t    stat
);
  import drc_pkg::*;

  localparam int NW = DEPTH_BITS + QUOT_BITS;

  div_state_t            dstate;
  div_state_t            dstate_next;
  logic [DEPTH_BITS-1:0] t_q;
  logic [DEPTH_BITS-1:0] span_q;
  logic [DEPTH_BITS-1:0] rem;
  logic [QUOT_BITS-1:0]  low_bits;
  logic [QUOT_BITS-1:0]  quot;
  logic [QCNT_W-1:0]     cnt;
  logic                  done;
  logic [NW-1:0]         num;
  logic [DEPTH_BITS:0]   trial;
  logic [DEPTH_BITS:0]   diff;
  logic                  fits;
  logic                  last;

  assign num   = NW'(t_q) * NW'(RAMP_GAIN);
  assign trial = {rem, low_bits[QUOT_BITS-1]};
  assign diff  = trial - {1'b0, span_q};
  assign fits  = trial >= {1'b0, span_q};
  assign last  = cnt == QCNT_W'(QUOT_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DIV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_comb begin
    dstate_next = dstate;
    unique case (dstate)
      DIV_IDLE: if (start) dstate_next = DIV_MUL;
      DIV_MUL:  dstate_next = DIV_RUN;
      DIV_RUN:  if (last) dstate_next = DIV_IDLE;
      default:  dstate_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (dstate == DIV_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    case (dstate)
      DIV_IDLE: begin
        if (start) begin
          t_q    <= t;
          span_q <= span;
        end
      end
      DIV_MUL: begin
        // the upper part is already below span, so only the low byte is shifted in
        rem      <= num[NW-1:QUOT_BITS];
        low_bits <= num[QUOT_BITS-1:0];
        quot     <= '0;
        cnt      <= '0;
      end
      DIV_RUN: begin
        rem      <= fits ? diff[DEPTH_BITS-1:0] : trial[DEPTH_BITS-1:0];
        quot     <= {quot[QUOT_BITS-2:0], fits};
        low_bits <= {low_bits[QUOT_BITS-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.done   = done;
  assign stat.rem_nz = |rem;
  assign stat.quot   = quot;

endmodule

[rtl/depth_range_colormap_unit.sv]
// Top level: depth range tracking and three-stop color ramp.
//
//   channel     dir  payload                request meaning
//   sample_in   in   cmd[1:0], depth[15:0]  clear+measure, measure or colorize
//   color_out   out  red, green, blue       one color per colorize request
//
// Measure, clear and unused requests are handled in the idle state. A colorize
// request that clamps to the red or blue stop goes through accept, classify and hand-off; one on the ramp through
// accept, classify, divider load, 8 quotient steps, done flag and hand-off.
// The output register frees the input side while a color waits to be taken;
// a finished color holds inside until that register is free. Reset is
// synchronous and sets the range empty (low all ones, high zero).
`timescale 1ns / 1ps

module depth_range_colormap_unit #(
  parameter int DEPTH_BITS = 16
) (
  input logic clk,
  input logic rst,
  drc_in_if.sink    sample_in,
  drc_out_if.source color_out
);
  import drc_pkg::*;

  localparam int PAD_W = DEPTH_BITS_MAX;

  ctl_state_t            state;
  ctl_state_t            state_next;
  logic                  accept;
  logic [DEPTH_BITS-1:0] d_in;
  logic [DEPTH_BITS-1:0] depth_q;
  logic [DEPTH_BITS-1:0] low;
  logic [DEPTH_BITS-1:0] high;
  logic                  range_upd;
  logic                  below;
  logic                  above;
  logic                  lower_half;
  logic                  seg_upper;
  logic [DEPTH_BITS:0]   z2;
  logic [DEPTH_BITS:0]   mid2;
  logic [DEPTH_BITS:0]   t_lower;
  logic [DEPTH_BITS:0]   t_upper;
  logic [DEPTH_BITS-1:0] t_calc;
  logic [DEPTH_BITS-1:0] span;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [CHAN_W-1:0]     rising;
  logic [CHAN_W-1:0]     falling;
  logic [CHAN_W-1:0]     res_r;
  logic [CHAN_W-1:0]     res_g;
  logic [CHAN_W-1:0]     res_b;
  logic                  out_valid;
  logic                  out_free;
  logic [DEPTH_IN_W+PAD_W-1:0] d_wide;

  assign d_wide = {{PAD_W{1'b0}}, sample_in.depth};
  assign d_in   = d_wide[DEPTH_BITS-1:0];

  assign accept    = sample_in.valid && sample_in.ready;
  assign range_upd = accept && (sample_in.cmd == CMD_CLEAR || sample_in.cmd == CMD_MEASURE);

  drc_range #(.DEPTH_BITS(DEPTH_BITS)) u_range (
    .clk   (clk),
    .rst   (rst),
    .upd   (range_upd),
    .clear (sample_in.cmd == CMD_CLEAR),
    .depth (d_in),
    .low   (low),
    .high  (high)
  );

  // classify on doubled depths so the midpoint stays exact
  assign z2         = {depth_q, 1'b0};
  assign mid2       = {1'b0, low} + {1'b0, high};
  assign below      = depth_q < low;
  assign above      = depth_q >= high;
  assign lower_half = z2 < mid2;
  assign t_lower    = z2 - {low, 1'b0};
  assign t_upper    = z2 - mid2;
  assign t_calc     = lower_half ? t_lower[DEPTH_BITS-1:0] : t_upper[DEPTH_BITS-1:0];
  assign span       = high - low;

  drc_sdiv #(.DEPTH_BITS(DEPTH_BITS)) u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .t     (t_calc),
    .span  (span),
    .stat  (div_stat)
  );

  // rising channel: gain*t/span truncated; falling: gain*(span-t)/span truncated
  assign rising  = STOP_LO + div_stat.quot;
  assign falling = STOP_HI - div_stat.quot - CHAN_W'(div_stat.rem_nz);

  assign out_free        = !out_valid || color_out.ready;
  assign sample_in.ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && sample_in.cmd == CMD_COLOR) state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (below || above) begin
          state_next = ST_RESULT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      depth_q <= d_in;
    end
    if (state == ST_CLASS) begin
      seg_upper <= !lower_half;
      if (below) begin
        res_r <= STOP_HI;
        res_g <= STOP_LO;
        res_b <= STOP_LO;
      end else begin
        res_r <= STOP_LO;
        res_g <= STOP_LO;
        res_b <= STOP_HI;
      end
    end
    if (state == ST_DIV && div_stat.done) begin
      if (seg_upper) begin
        res_r <= STOP_LO;
        res_g <= falling;
        res_b <= rising;
      end else begin
        res_r <= falling;
        res_g <= rising;
        res_b <= STOP_LO;
      end
    end
  end

  // output register: load a finished color, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (color_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      color_out.red   <= res_r;
      color_out.green <= res_g;
      color_out.blue  <= res_b;
    end
  end

  assign color_out.valid = out_valid;

endmodule

[dv/depth_range_colormap_checker.sv]
// Checker: tracks the depth range, predicts colors and scores the color channel.
`timescale 1ns / 1ps

module depth_range_colormap_checker
  import drc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  drc_in_if         smp,
  drc_out_if        col,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  localparam int REPORT_MAX = 10;

  logic [DEPTH_IN_W-1:0] span_lo;
  logic [DEPTH_IN_W-1:0] span_hi;
  color_t                color_due[$];
  int                    errs;

  // Truncated blend of c1 at p1 and c2 at p2 for p1 <= z < p2.
  function automatic logic [CHAN_W-1:0] blend_chan(longint unsigned z, longint unsigned p1,
                                                   longint unsigned p2, longint unsigned c1,
                                                   longint unsigned c2);
    longint unsigned span;
    span = p2 - p1;
    if (span == 0) begin
      return c1[CHAN_W-1:0];
    end
    return CHAN_W'((c2 * (z - p1) + c1 * (p2 - z)) / span);
  endfunction

  // Work on doubled depths so the midpoint stop stays an integer.
  function automatic color_t ramp_color(logic [DEPTH_IN_W-1:0] d, logic [DEPTH_IN_W-1:0] lo,
                                        logic [DEPTH_IN_W-1:0] hi);
    longint unsigned z, lo2, hi2, mid2;
    color_t c;
    z    = longint'(d) * 2;
    lo2  = longint'(lo) * 2;
    hi2  = longint'(hi) * 2;
    mid2 = longint'(lo) + longint'(hi);
    if (z < lo2) begin
      c.red = STOP_HI; c.green = STOP_LO; c.blue = STOP_LO;
    end else if (z >= hi2) begin
      c.red = STOP_LO; c.green = STOP_LO; c.blue = STOP_HI;
    end else if (z < mid2) begin
      c.red   = blend_chan(z, lo2, mid2, STOP_HI, STOP_LO);
      c.green = blend_chan(z, lo2, mid2, STOP_LO, STOP_HI);
      c.blue  = blend_chan(z, lo2, mid2, STOP_LO, STOP_LO);
    end else begin
      c.red   = blend_chan(z, mid2, hi2, STOP_LO, STOP_LO);
      c.green = blend_chan(z, mid2, hi2, STOP_HI, STOP_LO);
      c.blue  = blend_chan(z, mid2, hi2, STOP_LO, STOP_HI);
    end
    return c;
  endfunction

  always @(posedge clk) begin : watch
    color_t got;
    color_t want;
    if (rst) begin
      span_lo = '1;
      span_hi = '0;
      errs    = 0;
      color_due.delete();
    end else begin
      if (col.valid && col.ready) begin
        got.red   = col.red;
        got.green = col.green;
        got.blue  = col.blue;
        if (color_due.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX) begin
            $display("%0t: color with no request pending: r=%0d g=%0d b=%0d",
                     $realtime, got.red, got.green, got.blue);
          end
        end else begin
          want = color_due.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("%0t: color mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
          end
        end
      end
      if (smp.valid && smp.ready) begin
        case (smp.cmd) inside
          CMD_CLEAR, CMD_MEASURE: begin
            if (smp.cmd == CMD_CLEAR) begin
              span_lo = '1;
              span_hi = '0;
            end
            if (smp.depth < span_lo) span_lo = smp.depth;
            if (smp.depth > span_hi) span_hi = smp.depth;
          end
          CMD_COLOR: color_due.push_back(ramp_color(smp.depth, span_lo, span_hi));
          default: ;  // unused command: drop
        endcase
      end
    end
    pending    <= color_due.size();
    fail_count <= errs;
  end

endmodule

[dv/depth_range_colormap_unit_tb.sv]
// Testbench top: drives depth requests, paces the color receiver, gives the verdict.
`timescale 1ns / 1ps

module depth_range_colormap_unit_tb;
  import drc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_TARGET   = 1200;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   burst_left;
  bit   gaps_on;
  int   stall_reqs;
  int   idle_cycles;

  drc_in_if  sample_in ();
  drc_out_if color_out ();

  depth_range_colormap_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .color_out (color_out)
  );

  depth_range_colormap_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .smp        (sample_in),
    .col        (color_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Drop valid and wait, n giving the length of the wait; call before any wait that is not an offer.
  task automatic pause(input int n);
    @(negedge clk);
    sample_in.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic offer(input logic [CMD_W-1:0] c, input logic [DEPTH_IN_W-1:0] d);
    @(negedge clk);
    sample_in.valid <= 1'b1;
    sample_in.cmd   <= c;
    sample_in.depth <= d;
    do @(posedge clk); while (!sample_in.ready);
    if (c != CMD_UNUSED) items_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        pause($urandom_range(1, 8));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic drain_colors();
    pause(1);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly depths inside the current range, plus its edges and wild values.
  function automatic logic [DEPTH_IN_W-1:0] pick_depth(logic [DEPTH_IN_W-1:0] lo,
                                                       logic [DEPTH_IN_W-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return (lo <= hi) ? DEPTH_IN_W'($urandom_range(hi, lo))
                                          : DEPTH_IN_W'($urandom);
      6: return lo - 1'b1;
      7: return hi;
      8: return lo;
      default: return DEPTH_IN_W'($urandom);
    endcase
  endfunction

  initial begin : rx_side
    int cyc;
    int hold_left;
    int mode;
    int stall_seen;
    color_out.ready = 1'b0;
    cyc        = 0;
    hold_left  = 0;
    mode       = 0;
    stall_seen = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        hold_left  = LONG_HOLD;
      end
      if (cyc % 200 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        color_out.ready <= 1'b0;
      end else begin
        case (mode)
          0: color_out.ready <= 1'b1;
          1: color_out.ready <= 1'($urandom_range(0, 1));
          2: color_out.ready <= (cyc % 4 == 0);
          default: color_out.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_in.valid && sample_in.ready) || (color_out.valid && color_out.ready))
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[depth_range_colormap_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                    phase;
    int                    spread;
    int                    n_meas;
    int                    n_color;
    logic [DEPTH_IN_W-1:0] base;
    logic [DEPTH_IN_W-1:0] d;
    logic [DEPTH_IN_W-1:0] lo;
    logic [DEPTH_IN_W-1:0] hi;
    bit                    keep_range;

    rst             = 1'b1;
    sample_in.valid = 1'b0;
    sample_in.cmd   = CMD_MEASURE;
    sample_in.depth = '0;
    items_sent      = 0;
    burst_left      = 4;
    gaps_on         = 1'b1;
    stall_reqs      = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty range right after reset
    offer(CMD_COLOR, 16'd0);
    offer(CMD_COLOR, 16'hFFFF);
    offer(CMD_COLOR, 16'hFFFE);
    offer(CMD_UNUSED, 16'hFFFF);
    // single-point range
    offer(CMD_CLEAR, 16'd500);
    offer(CMD_COLOR, 16'd499);
    offer(CMD_COLOR, 16'd500);
    offer(CMD_COLOR, 16'd501);
    // both ramp segments and the stops
    offer(CMD_MEASURE, 16'd1500);
    offer(CMD_COLOR, 16'd500);
    offer(CMD_COLOR, 16'd750);
    offer(CMD_COLOR, 16'd1000);
    offer(CMD_COLOR, 16'd1250);
    offer(CMD_COLOR, 16'd1499);
    offer(CMD_COLOR, 16'd1500);
    // full-scale range
    offer(CMD_CLEAR, 16'd0);
    offer(CMD_MEASURE, 16'hFFFF);
    offer(CMD_COLOR, 16'd0);
    offer(CMD_COLOR, 16'd32767);
    offer(CMD_COLOR, 16'd32768);
    offer(CMD_COLOR, 16'hFFFE);
    offer(CMD_COLOR, 16'hFFFF);
    offer(CMD_CLEAR, 16'hFFFF);
    offer(CMD_COLOR, 16'hFFFE);
    offer(CMD_COLOR, 16'hFFFF);
    offer(CMD_UNUSED, 16'h0000);
    lo = 16'hFFFF;
    hi = 16'hFFFF;

    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      phase++;
      gaps_on    = (phase % 4 != 1);
      keep_range = ($urandom_range(0, 5) == 0);
      base       = DEPTH_IN_W'($urandom);
      spread     = 1 << $urandom_range(0, 16);
      offer(keep_range ? CMD_MEASURE : CMD_CLEAR, base);
      if (keep_range) begin
        if (base < lo) lo = base;
        if (base > hi) hi = base;
      end else begin
        lo = base;
        hi = base;
      end
      n_meas = $urandom_range(0, 5);
      repeat (n_meas) begin
        d = base + DEPTH_IN_W'($urandom_range(0, spread));
        offer(CMD_MEASURE, d);
        if (d < lo) lo = d;
        if (d > hi) hi = d;
      end
      // hold the receiver off while requests keep coming
      if (phase == 4) stall_reqs++;
      n_color = $urandom_range(8, 40);
      repeat (n_color) begin
        case ($urandom_range(0, 19))
          0: offer(CMD_UNUSED, DEPTH_IN_W'($urandom));
          1: begin
            d = pick_depth(lo, hi);
            offer(CMD_MEASURE, d);
            if (d < lo) lo = d;
            if (d > hi) hi = d;
          end
          2: offer(CMD_COLOR, DEPTH_IN_W'($urandom));
          default: offer(CMD_COLOR, pick_depth(lo, hi));
        endcase
      end
      if (phase % 5 == 0) drain_colors();
    end

    drain_colors();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[depth_range_colormap_unit] OK");
    end else begin
      $display("[depth_range_colormap_unit] ERROR");
    end
    $finish;
  end

endmodule
